[src/esc_pkg.sv]
// Shared types and constants for the C string escaper.
`default_nettype none

package esc_pkg;

  // Most characters one item can expand to (closing quote plus _Init).
  localparam int MaxOut = 6;
  localparam int LenW   = $clog2(MaxOut + 1);
  localparam int PosW   = $clog2(MaxOut);

  typedef logic [7:0]                  char_t;
  typedef logic [MaxOut-1:0][7:0]      run_chars_t;
  typedef logic [LenW-1:0]             run_len_t;
  typedef logic [PosW-1:0]             run_pos_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_QUOTE_ENABLE  = 2'd0,
    CFG_NEWLINE_PASS  = 2'd1,
    CFG_APPEND_SUFFIX = 2'd2
  } cfg_idx_t;

  localparam char_t ChQuote     = 8'h22;
  localparam char_t ChBackslash = 8'h5C;
  localparam char_t ChTab       = 8'h09;
  localparam char_t ChCr        = 8'h0D;
  localparam char_t ChLf        = 8'h0A;
  localparam char_t ChSpace     = 8'h20;
  localparam char_t ChTilde     = 8'h7E;
  localparam char_t ChLowerT    = 8'h74;
  localparam char_t ChLowerR    = 8'h72;
  localparam char_t ChLowerN    = 8'h6E;
  localparam char_t ChLowerX    = 8'h78;
  localparam char_t ChUnder     = 8'h5F;
  localparam char_t ChUpperI    = 8'h49;
  localparam char_t ChLowerI    = 8'h69;

  // Uppercase hex digit for one nibble.
  function automatic char_t hex_digit(input logic [3:0] nib);
    char_t ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

[src/c_string_escaper_unit.sv]
// Top level of the C string escaper: input register, expansion, run buffer, output register.
`default_nettype none

// Turns start, data and end items into the characters of a C string literal,
// one character per output beat. Each accepted item is registered, expanded
// combinationally into a run of up to six characters, and the run is played
// out from a buffer through the output register at one character per cycle
// while char_stall is low. A plain byte yields 1 character, a short escape 2,
// a hex escape 4, and an end item with quote and suffix 6. The output port
// is the limit; the next item is taken while the current run is still going
// out. Items that yield nothing are dropped at the run buffer. Each character
// passes the input register, the run buffer and the output register in turn.
// The configuration port is always ready; write it only while the block is idle.
module c_string_escaper_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output      logic                item_stall,
  input  wire logic [1:0]          op,
  input  wire logic [7:0]          data_byte,
  output      logic                char_valid,
  input  wire logic                char_stall,
  output      esc_pkg::char_t      out_char,
  output      logic                last_of_run,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);
  import esc_pkg::*;

  logic       quote_enable;
  logic       newline_pass;
  logic       append_init_suffix;

  logic       ir_valid;
  logic [1:0] ir_op;
  char_t      ir_byte;

  logic       rb_valid;
  run_chars_t rb_chars;
  run_len_t   rb_len;
  run_pos_t   rb_pos;

  run_chars_t exp_chars;
  run_len_t   exp_len;

  logic out_free;
  logic rb_last;
  logic rb_free;
  logic ir_free;
  logic plain;
  logic nl_ok;

  assign cfg_ready  = 1'b1;
  assign out_free   = !char_valid || !char_stall;
  assign rb_last    = (rb_pos == PosW'(rb_len - LenW'(1)));
  assign rb_free    = !rb_valid || (out_free && rb_last);
  assign ir_free    = !ir_valid || rb_free;
  assign item_stall = !ir_free;

  assign plain = (ir_byte >= ChSpace) && (ir_byte <= ChTilde) &&
                 (ir_byte != ChBackslash) && (ir_byte != ChQuote);
  assign nl_ok = (ir_byte == ChLf) && newline_pass;

  // Expand the registered item into its run of characters.
  always_comb begin
    exp_chars = '0;
    exp_len   = '0;
    case (ir_op)
      OP_START: begin
        if (quote_enable) begin
          exp_chars[0] = ChQuote;
          exp_len      = LenW'(1);
        end
      end
      OP_DATA: begin
        if (!quote_enable || plain || nl_ok) begin
          exp_chars[0] = ir_byte;
          exp_len      = LenW'(1);
        end else begin
          exp_chars[0] = ChBackslash;
          exp_len      = LenW'(2);
          case (ir_byte)
            ChQuote:     exp_chars[1] = ChQuote;
            ChBackslash: exp_chars[1] = ChBackslash;
            ChTab:       exp_chars[1] = ChLowerT;
            ChCr:        exp_chars[1] = ChLowerR;
            ChLf:        exp_chars[1] = ChLowerN;
            default: begin
              exp_chars[1] = ChLowerX;
              exp_chars[2] = hex_digit(ir_byte[7:4]);
              exp_chars[3] = hex_digit(ir_byte[3:0]);
              exp_len      = LenW'(4);
            end
          endcase
        end
      end
      OP_END: begin
        if (quote_enable && append_init_suffix) begin
          exp_chars[0] = ChQuote;
          exp_chars[1] = ChUnder;
          exp_chars[2] = ChUpperI;
          exp_chars[3] = ChLowerN;
          exp_chars[4] = ChLowerI;
          exp_chars[5] = ChLowerT;
          exp_len      = LenW'(6);
        end else if (quote_enable) begin
          exp_chars[0] = ChQuote;
          exp_len      = LenW'(1);
        end else if (append_init_suffix) begin
          exp_chars[0] = ChUnder;
          exp_chars[1] = ChUpperI;
          exp_chars[2] = ChLowerN;
          exp_chars[3] = ChLowerI;
          exp_chars[4] = ChLowerT;
          exp_len      = LenW'(5);
        end
      end
      default: begin
        exp_len = '0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_enable       <= 1'b1;
      newline_pass       <= 1'b0;
      append_init_suffix <= 1'b0;
      ir_valid           <= 1'b0;
      rb_valid           <= 1'b0;
      rb_pos             <= '0;
      char_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUOTE_ENABLE:  quote_enable       <= cfg_data[0];
          CFG_NEWLINE_PASS:  newline_pass       <= cfg_data[0];
          CFG_APPEND_SUFFIX: append_init_suffix <= cfg_data[0];
          default:           ;
        endcase
      end
      if (ir_free) begin
        ir_valid <= item_valid;
      end
      if (rb_free) begin
        // An item with an empty run is dropped here.
        rb_valid <= ir_valid && (exp_len != '0);
        rb_pos   <= '0;
      end else if (out_free) begin
        rb_pos <= rb_pos + PosW'(1);
      end
      if (out_free) begin
        char_valid <= rb_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ir_free) begin
      ir_op   <= op;
      ir_byte <= data_byte;
    end
    if (rb_free) begin
      rb_chars <= exp_chars;
      rb_len   <= exp_len;
    end
    if (out_free && rb_valid) begin
      out_char    <= rb_chars[rb_pos];
      last_of_run <= rb_last;
    end
  end

endmodule

`default_nettype wire

[src/esc_checker.sv]
// Port-level checks for the C string escaper, bound to the top level.
`default_nettype none

module esc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       char_valid,
  input wire logic       char_stall,
  input wire logic [7:0] out_char,
  input wire logic       last_of_run,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready
);

  // Characters of the current run already delivered.
  logic [2:0] run_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (char_valid && !char_stall) begin
      run_cnt <= last_of_run ? 3'd0 : run_cnt + 3'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(out_char) && $stable(last_of_run))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !char_valid)
    else $error("output beat straight after reset");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && !last_of_run |-> run_cnt < 3'd5)
    else $error("run longer than six characters");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind c_string_escaper_unit esc_checker u_esc_checker (.*);

`default_nettype wire

[tb/sv/tb_c_string_escaper_unit.sv]
// Testbench for the C string escaper: random stimulus and a scoreboard that predicts each character.
`timescale 1ns / 100ps

module tb_c_string_escaper_unit;
  import esc_pkg::*;

  localparam logic [1:0] OpSpare     = 2'd3;  // op code the block ignores
  localparam logic [1:0] CfgIdxSpare = 2'd3;  // register index beyond the list
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 32;

  typedef struct packed {
    char_t ch;
    logic  last;
  } char_beat_t;

  class escape_scoreboard;
    logic       quote_on;
    logic       newline_ok;
    logic       suffix_on;
    char_beat_t pending_chars[$];
    int         mismatches;

    function new();
      quote_on   = 1'b1;
      newline_ok = 1'b0;
      suffix_on  = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        CFG_QUOTE_ENABLE:  quote_on   = value[0];
        CFG_NEWLINE_PASS:  newline_ok = value[0];
        CFG_APPEND_SUFFIX: suffix_on  = value[0];
        default: ;
      endcase
    endfunction

    function char_t nib_char(logic [3:0] nib);
      return (nib < 4'd10) ? char_t'(8'h30 + nib) : char_t'(8'h41 + nib - 4'd10);
    endfunction

    // Expand one accepted item into the characters it should produce.
    function void note_item(logic [1:0] o, char_t b);
      char_t run[$];
      logic  plain;
      run = {};
      plain = (b >= ChSpace) && (b <= ChTilde) && (b != ChBackslash) && (b != ChQuote);
      case (o)
        OP_START: begin
          if (quote_on) run.push_back(ChQuote);
        end
        OP_DATA: begin
          if (!quote_on || plain || (b == ChLf && newline_ok)) begin
            run.push_back(b);
          end else begin
            run.push_back(ChBackslash);
            case (b)
              ChQuote:     run.push_back(ChQuote);
              ChBackslash: run.push_back(ChBackslash);
              ChTab:       run.push_back(ChLowerT);
              ChCr:        run.push_back(ChLowerR);
              ChLf:        run.push_back(ChLowerN);
              default: begin
                run.push_back(ChLowerX);
                run.push_back(nib_char(b[7:4]));
                run.push_back(nib_char(b[3:0]));
              end
            endcase
          end
        end
        OP_END: begin
          if (quote_on) run.push_back(ChQuote);
          if (suffix_on) begin
            run.push_back(ChUnder);
            run.push_back(ChUpperI);
            run.push_back(ChLowerN);
            run.push_back(ChLowerI);
            run.push_back(ChLowerT);
          end
        end
        default: ;
      endcase
      foreach (run[k]) pending_chars.push_back('{ch: run[k], last: (k == run.size() - 1)});
    endfunction

    task report(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_char(input char_t ch, input logic last);
      char_beat_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("char %02h arrived with nothing expected", ch));
      end else begin
        want = pending_chars.pop_front();
        if (ch !== want.ch)
          report($sformatf("out_char %02h, expected %02h", ch, want.ch));
        if (last !== want.last)
          report($sformatf("last_of_run %b on char %02h, expected %b", last, ch, want.last));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] op = 2'd0;
  logic [7:0] data_byte = 8'd0;
  logic       char_valid;
  logic       char_stall = 1'b0;
  char_t      out_char;
  logic       last_of_run;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;

  escape_scoreboard sb = new();
  logic idling_on = 1'b1;
  int   cycle_count = 0;

  c_string_escaper_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .op          (op),
    .data_byte   (data_byte),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: random stall before each beat while idling is on, check every accepted beat.
  initial begin
    int n;
    wait (!rst);
    forever begin
      n = idling_on ? $urandom_range(0, 4) : 0;
      if (n > 0) begin
        char_stall <= 1'b1;
        repeat (n) @(posedge clk);
        char_stall <= 1'b0;
      end
      @(posedge clk);
      while (!char_valid) @(posedge clk);
      sb.check_char(out_char, last_of_run);
    end
  end

  task automatic send_item(input logic [1:0] o, input logic [7:0] b);
    int gap;
    gap = idling_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    data_byte  <= b;
    do @(posedge clk); while (item_stall);
    sb.note_item(o, b);
  endtask

  // Lower valid and hold off until every expected char is out.
  task automatic hold_until_empty();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic drain();
    hold_until_empty();
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Upper data bits are junk; the spare index gets a write that must be ignored.
  task automatic apply_config(input logic q, input logic nl, input logic sfx);
    logic [1:0] idx[4];
    logic [7:0] vals[4];
    idx[0]  = CFG_QUOTE_ENABLE;
    idx[1]  = CFG_NEWLINE_PASS;
    idx[2]  = CFG_APPEND_SUFFIX;
    idx[3]  = CfgIdxSpare;
    vals[0] = (8'($urandom) & 8'hFE) | {7'd0, q};
    vals[1] = (8'($urandom) & 8'hFE) | {7'd0, nl};
    vals[2] = (8'($urandom) & 8'hFE) | {7'd0, sfx};
    vals[3] = 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_byte();
    logic [7:0] specials[5];
    specials = '{ChQuote, ChBackslash, ChTab, ChCr, ChLf};
    case ($urandom_range(0, 3))
      0:       return specials[$urandom_range(0, 4)];
      1:       return 8'($urandom_range(8'h20, 8'h7E));
      2:       return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] directed_bytes[$];
    int count;
    int k;
    logic [1:0] o;
    directed_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h20, 8'h7E, 8'h1F, 8'h41,
                       ChQuote, ChBackslash, ChTab, ChCr, ChLf, 8'h5A, 8'hA5};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes, all escapes, ignored op, stray data bytes.
    send_item(OP_START, 8'h00);
    foreach (directed_bytes[i]) send_item(OP_DATA, directed_bytes[i]);
    send_item(OP_END, 8'h00);
    send_item(OpSpare, 8'hFF);
    send_item(OP_START, 8'hFF);
    send_item(OP_END, 8'hA5);
    drain();

    // One phase per setting of the three registers.
    for (int c = 0; c < 8; c++) begin
      apply_config(c[0], c[1], c[2]);
      idling_on = ($urandom_range(0, 3) != 0);
      count = 0;
      while (count < PhaseItems) begin
        if ($urandom_range(0, 4) == 0) begin
          o = 2'($urandom_range(0, 3));
          send_item(o, 8'($urandom));
          if (o != OpSpare) count++;
        end else begin
          k = $urandom_range(0, 6);
          send_item(OP_START, 8'($urandom));
          repeat (k) send_item(OP_DATA, random_byte());
          send_item(OP_END, 8'($urandom));
          count += k + 2;
        end
        if (c == 3 && count >= PhaseItems / 2 && count < PhaseItems / 2 + 9)
          hold_until_empty();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
